// File: src/sha256_stream_hasher_assert.svh
// Assertion macros for the SHA-256 stream hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Implication checked every clock, skipped while in reset
`define SHA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, skipped while in reset
`define SHA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/sha_pkg.sv
package sha_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Request opcodes
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Request from front to back
    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_req;

    // Back-end states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROM [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

// File: src/sha_front.sv
// Input queue: takes requests and holds them until the core is free
module sha_front import sha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_op,
    input  logic [7:0] i_data_byte,
    output logic       o_req_valid,
    output t_req       o_req,
    input  logic       i_req_take
);
    t_req           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_wr, w_rd;

    assign o_full      = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_mem[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_req_take && o_req_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= '{op: i_op, data: i_data_byte};
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(w_wr) - (QAW+1)'(w_rd);
        end
    end

    `include "sha256_stream_hasher_assert.svh"
    `SHA_ASSERT_IMP(a_cnt_max, 1'b1, r_cnt <= (QAW+1)'(QDEPTH))
    `SHA_ASSERT_NXT(a_full_hold, o_full && !w_rd, o_full)
    `SHA_ASSERT_NXT(a_wr_count, w_wr && !w_rd, r_cnt == $past(r_cnt) + 1'b1)
endmodule

// File: src/sha_core.sv
// Block buffer, padding and 64-round compression; one round per cycle
module sha_core import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  t_req        i_req,
    output logic        o_req_take,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    logic [31:0] r_buf [16];
    logic [31:0] r_h [8], r_v [8], r_w [16];
    logic [5:0]  r_fill, r_pidx;
    logic [63:0] r_bits;
    logic [5:0]  r_rnd;
    logic [3:0]  r_ld;
    logic [2:0]  r_oidx;
    logic        r_fin, r_second;
    t_state      r_st, n_st;

    // Round logic
    logic [31:0] w_w2, w_w7, w_w15, w_wnew, w_wcur, w_t1, w_t2, w_a, w_e;
    logic [3:0]  w_slot;
    logic        w_take, w_pop;
    logic [7:0]  w_pbyte;

    assign w_slot = r_rnd[3:0];
    assign w_w2   = r_w[w_slot - 4'd2];
    assign w_w7   = r_w[w_slot - 4'd7];
    assign w_w15  = r_w[w_slot - 4'd15];
    assign w_wnew = (rotr(w_w2, 17) ^ rotr(w_w2, 19) ^ (w_w2 >> 10)) + w_w7
                  + (rotr(w_w15, 7) ^ rotr(w_w15, 18) ^ (w_w15 >> 3)) + r_w[w_slot];
    assign w_wcur = (r_rnd >= 6'd16) ? w_wnew : r_w[w_slot];
    assign w_a    = r_v[0];
    assign w_e    = r_v[4];
    assign w_t1   = r_v[7] + (rotr(w_e, 6) ^ rotr(w_e, 11) ^ rotr(w_e, 25))
                  + ((w_e & r_v[5]) ^ (~w_e & r_v[6])) + K_ROM[r_rnd] + w_wcur;
    assign w_t2   = (rotr(w_a, 2) ^ rotr(w_a, 13) ^ rotr(w_a, 22))
                  + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign o_req_take = (r_st == ST_IDLE) && i_req_valid;
    assign w_take     = o_req_take;
    assign w_pop      = i_pop && !o_empty;

    // Padding byte for position r_pidx
    always_comb begin
        if (r_pidx == r_fill && !r_second) begin
            w_pbyte = 8'h80;
        end else if (r_pidx >= 6'd56 && (r_fill < 6'd56 || r_second)) begin
            w_pbyte = r_bits[8*(7 - 32'(r_pidx[2:0])) +: 8];
        end else begin
            w_pbyte = 8'h00;
        end
    end

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (w_take && i_req.op == OP_FINISH) n_st = ST_PAD;
                else if (w_take && r_fill == 6'd63) n_st = ST_LOAD;
            end
            ST_PAD:   if (r_pidx == 6'd63) n_st = ST_LOAD;
            ST_LOAD:  if (r_ld == 4'd15) n_st = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'd63) n_st = ST_ADD;
            ST_ADD: begin
                if (!r_fin) n_st = ST_IDLE;
                else if (r_fill >= 6'd56 && !r_second) n_st = ST_PAD;
                else n_st = ST_EMIT;
            end
            ST_EMIT:  if (w_pop && r_oidx == 3'd7) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_empty       = (r_st != ST_EMIT);
        o_digest_word = r_h[r_oidx];
        o_word_index  = r_oidx;
        o_last_word   = (r_oidx == 3'd7);
    end

    // Block buffer memory, four bytes per word, first byte in the top lane
    always_ff @(posedge i_clk) begin
        if (w_take && i_req.op == OP_ABSORB) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_req.data;
        end else if (r_st == ST_PAD && (r_pidx >= r_fill || r_second)) begin
            r_buf[r_pidx[5:2]][{~r_pidx[1:0], 3'b000} +: 8] <= w_pbyte;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_st == ST_LOAD) begin
            r_w[r_ld] <= r_buf[r_ld];
            if (r_ld == 4'd0) begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
        end else if (r_st == ST_ROUND) begin
            r_w[w_slot] <= w_wcur;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= w_e;
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= w_a;
            r_v[0] <= w_t1 + w_t2;
        end
    end

    // Control and chain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_fill <= '0; r_bits <= '0; r_pidx <= '0; r_ld <= '0; r_rnd <= '0;
            r_oidx <= '0; r_fin <= 1'b0; r_second <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            r_st <= n_st;
            if (w_take && i_req.op == OP_ABSORB) begin
                r_fill <= r_fill + 1'b1;
                r_bits <= r_bits + 64'd8;
            end
            if (w_take && i_req.op == OP_FINISH) begin
                r_fin  <= 1'b1;
                r_pidx <= '0;
            end
            if (r_st == ST_PAD) r_pidx <= r_pidx + 1'b1;
            if (r_st == ST_LOAD) r_ld <= r_ld + 1'b1;
            if (r_st == ST_ROUND) r_rnd <= r_rnd + 1'b1;
            if (r_st == ST_ADD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                if (r_fin && r_fill >= 6'd56 && !r_second) begin
                    r_second <= 1'b1;
                    r_pidx   <= '0;
                end
            end
            if (w_pop) begin
                r_oidx <= r_oidx + 1'b1;
                if (r_oidx == 3'd7) begin
                    r_fill <= '0; r_bits <= '0; r_fin <= 1'b0; r_second <= 1'b0;
                    for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
                end
            end
        end
    end

    `include "sha256_stream_hasher_assert.svh"
    `SHA_ASSERT_IMP(a_take_idle, o_req_take, r_st == ST_IDLE)
    `SHA_ASSERT_IMP(a_emit_fin, !o_empty, r_fin)
    `SHA_ASSERT_NXT(a_round_adv, r_st == ST_ROUND && r_rnd != 6'd63, r_st == ST_ROUND)
    `SHA_ASSERT_IMP(a_idle_oidx, r_st == ST_IDLE, r_oidx == 3'd0)
endmodule

// File: src/sha256_stream_hasher.sv
// SHA-256 stream hasher.
// Input queue: drive i_op/i_data_byte and raise push; a request is taken
// on a clock edge where push is high and full is low. op 0 absorbs one
// byte, op 1 pads the message and produces the digest.
// Output queue: while empty is low the next digest word sits on
// o_digest_word/o_word_index/o_last_word; pop takes it. Eight words follow
// each finish request, word 0 first, o_last_word set on word 7.
// Flow: a request is stored in the input queue before the core takes it. A
// byte is absorbed into the block buffer; when it fills a block the core
// loads 16 words, runs 64 rounds and adds. Finish pads and compresses each
// block it closes (one or two), then the words are presented. Rounds run
// one per cycle in a single shared round unit, which sets the throughput.
// A four-entry input queue decouples the sender from the core.
// Reset (synchronous, i_rst_n low) empties the queue and loads the initial
// hash values. If the receiver stalls, the core holds the current word and
// the input queue fills, then full stays high until words are popped.
module sha256_stream_hasher import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    logic w_req_valid, w_req_take;
    t_req w_req;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_op, .i_data_byte,
        .o_req_valid(w_req_valid), .o_req(w_req), .i_req_take(w_req_take)
    );

    sha_core u_core (
        .i_clk, .i_rst_n, .i_req_valid(w_req_valid), .i_req(w_req),
        .o_req_take(w_req_take), .o_empty(empty), .i_pop(pop),
        .o_digest_word, .o_word_index, .o_last_word
    );
endmodule

// File: test/sha256_digest_checker.sv
// Watches both queues of the hasher, predicts each digest and compares it word by word.
module sha256_digest_checker import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] o_digest_word,
    input  logic [2:0]  o_word_index,
    input  logic        o_last_word,
    output int          o_mismatch_count,
    output int          o_words_pending
);

    // One predicted digest word
    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    t_digest_word digest_q[$];
    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    logic [5:0]   block_fill;
    logic [63:0]  msg_bits;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Compress msg_block into hash_state
    task automatic compress_msg_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        int slot;
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int r = 0; r < 64; r++) begin
            slot = r & 15;
            if (r >= 16) begin
                s1 = ror32(w[(r-2)&15], 17) ^ ror32(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                s0 = ror32(w[(r-15)&15], 7) ^ ror32(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                w[slot] = s1 + w[(r-7)&15] + s0 + w[slot];
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROM[r] + w[slot];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
        block_fill = '0;
        msg_bits   = '0;
    endtask

    // Pad, compress and queue the eight digest words
    task automatic finish_message();
        t_digest_word d;
        msg_block[block_fill] = 8'h80;
        for (int i = block_fill + 1; i < 64; i++) msg_block[i] = '0;
        if (block_fill >= 56) begin
            compress_msg_block();
            for (int i = 0; i < 64; i++) msg_block[i] = '0;
        end
        for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[8*(7-i) +: 8];
        compress_msg_block();
        for (int i = 0; i < 8; i++) begin
            d.word = hash_state[i];
            d.index = i[2:0];
            d.last = (i == 7);
            digest_q = {digest_q, d};
        end
        restart_message();
    endtask

    always @(posedge i_clk) begin
        t_digest_word e;
        if (!i_rst_n) begin
            digest_q.delete();
            restart_message();
            o_mismatch_count <= 0;
        end else begin
            // Result side
            if (pop && !empty) begin
                if (digest_q.size() == 0) begin
                    if (o_mismatch_count < 10)
                        $display("unexpected digest word %h idx %0d", o_digest_word,
                                 o_word_index);
                    o_mismatch_count <= o_mismatch_count + 1;
                end else begin
                    e = digest_q.pop_front();
                    if (e.word !== o_digest_word || e.index !== o_word_index ||
                        e.last !== o_last_word) begin
                        if (o_mismatch_count < 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     e.word, e.index, e.last, o_digest_word,
                                     o_word_index, o_last_word);
                        o_mismatch_count <= o_mismatch_count + 1;
                    end
                end
            end
            // Request side
            if (push && !full) begin
                if (i_op == OP_ABSORB) begin
                    msg_block[block_fill] = i_data_byte;
                    msg_bits   += 64'd8;
                    block_fill += 6'd1;
                    if (block_fill == 0) compress_msg_block();
                end else begin
                    finish_message();
                end
            end
        end
        o_words_pending <= digest_q.size();
    end

endmodule

// File: test/sha256_stream_hasher_test.sv
module sha256_stream_hasher_test import sha_pkg::*;;

    localparam int   CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_op;
    logic [7:0]  i_data_byte;
    logic        empty;
    logic        pop;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;
    int          mismatch_count;
    int          words_pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          cycle_count;
    int          items_sent;

    sha256_stream_hasher u_dut (.*);

    sha256_digest_checker u_checker (
        .i_clk, .i_rst_n, .push, .full, .i_op, .i_data_byte, .empty, .pop,
        .o_digest_word, .o_word_index, .o_last_word,
        .o_mismatch_count(mismatch_count), .o_words_pending(words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or held off entirely
    always @(posedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one request, honoring the sender idle rate, until accepted.
    // push stays high on return; the next call or the caller drops it.
    task automatic send_request(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_message(input int len, input int pattern);
        for (int i = 0; i < len; i++)
            case (pattern)
                0: send_request(OP_ABSORB, 8'h00);
                1: send_request(OP_ABSORB, 8'hff);
                default: send_request(OP_ABSORB, 8'($urandom));
            endcase
        send_request(OP_FINISH, 8'($urandom));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int len;
        push = 1'b0; i_op = OP_ABSORB; i_data_byte = '0;
        hold_off = 1'b0; items_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, byte extremes, padding boundaries
        send_message(0, 2);
        send_message(1, 0);
        send_message(1, 1);
        send_message(3, 2);
        wait_drained();
        send_message(57, 1);
        send_message(64, 2);
        wait_drained();

        // Long receiver hold-off while the sender keeps going
        hold_off = 1'b1;
        fork
            begin
                send_message(2, 2);
                send_message(6, 2);
                send_message(1, 2);
                push <= 1'b0;
                @(posedge i_clk);
            end
            begin
                repeat (2000) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        wait_drained();

        // Random phases of idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int m = 0; m < 3; m++) begin
                len = $urandom_range(4);
                send_message(len, 2);
            end
            if (ph == 1) wait_drained();
        end
        while (items_sent < 180) begin
            len = $urandom_range(4);
            send_message(len, 2);
        end

        wait_drained();
        repeat (400) @(posedge i_clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/sha_pkg.sv
src/sha_front.sv
src/sha_core.sv
src/sha256_stream_hasher.sv
test/sha256_digest_checker.sv
test/sha256_stream_hasher_test.sv
